// ----- hw/rtl/hrhp_pkg.sv -----
// hrhp_pkg: shared types, constants and the hex digit decoder for the
// hex record halfword parser. No dependencies.
package hrhp_pkg;

   // character codes of the record format
   localparam logic [7:0] CHAR_MARK     = 8'h3A;  // ':'
   localparam logic [7:0] CHAR_ZERO     = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE     = 8'h39;  // '9'
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_UPPER_F  = 8'h46;  // 'F'
   localparam logic [7:0] LETTER_OFFSET = 8'd55;  // 'A' - 10

   // character positions inside a record
   localparam logic [9:0] POS_COUNT_LOW  = 10'd2;   // second byte count digit
   localparam logic [9:0] POS_OFFSET_LOW = 10'd6;   // last offset digit
   localparam logic [9:0] POS_TYPE_LOW   = 10'd8;   // last record type digit
   localparam logic [9:0] POS_DATA_FIRST = 10'd9;   // first data digit

   // one finished halfword handed from the front to the back
   typedef struct packed {
      logic [15:0] offset;
      logic [15:0] halfword;
      logic [6:0]  word_index;
      logic        last;
   } entry_type;

   // ascii hex digit to nibble, anything else counts as zero
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] diff;
      begin
         diff = 8'd0;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff = c - CHAR_ZERO;
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            diff = c - LETTER_OFFSET;
         end
         return diff[3:0];
      end
   endfunction

endpackage

// ----- hw/rtl/hrhp_front.sv -----
// hrhp_front: takes record characters, tracks the record fields and
// assembles halfwords into queue entries. Depends on hrhp_pkg.
module hrhp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                char_valid,
   input  logic [7:0]          char_data,
   output logic                push,
   output hrhp_pkg::entry_type push_entry
);
   import hrhp_pkg::*;

   logic [9:0]  pos_ff, pos_in;
   logic        in_record_ff, in_record_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] acc_ff, acc_in;
   logic [6:0]  index_ff, index_in;

   logic [6:0]  total;
   logic [15:0] acc_next;
   logic [7:0]  index_inc;
   logic        emit;

   assign total     = byte_count_ff[7:1];
   assign acc_next  = {acc_ff[11:0], nibble_of(char_data)};
   assign index_inc = {1'b0, index_ff} + 8'd1;

   // record field tracking per transfer
   always_comb begin
      pos_in       = pos_ff;
      in_record_in = in_record_ff;
      byte_count_in = byte_count_ff;
      offset_in    = offset_ff;
      acc_in       = acc_ff;
      index_in     = index_ff;
      emit         = 1'b0;
      if (char_valid) begin
         if (char_data == CHAR_MARK) begin
            in_record_in  = 1'b1;
            pos_in        = 10'd1;
            byte_count_in = 8'd0;
            offset_in     = 16'd0;
            acc_in        = 16'd0;
            index_in      = 7'd0;
         end else if (in_record_ff) begin
            pos_in = pos_ff + 10'd1;
            acc_in = acc_next;
            if (pos_ff == POS_COUNT_LOW) begin
               byte_count_in = acc_next[7:0];
            end else if (pos_ff == POS_OFFSET_LOW) begin
               offset_in = acc_next;
            end else if (pos_ff < POS_DATA_FIRST) begin
               if (pos_ff == POS_TYPE_LOW && total == 7'd0) begin
                  in_record_in = 1'b0;
               end
            end else if (pos_ff[1:0] == 2'b00) begin
               // fourth digit of a group
               emit     = 1'b1;
               index_in = index_inc[6:0];
               if (index_inc[6:0] >= total) begin
                  in_record_in = 1'b0;
               end
            end
         end
      end
   end

   assign push                  = emit;
   assign push_entry.offset     = offset_ff;
   assign push_entry.halfword   = acc_next;
   assign push_entry.word_index = index_ff;
   assign push_entry.last       = (index_inc == {1'b0, total});

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_record_ff  <= 1'b0;
         pos_ff        <= 10'd0;
         byte_count_ff <= 8'd0;
         index_ff      <= 7'd0;
      end else begin
         in_record_ff  <= in_record_in;
         pos_ff        <= pos_in;
         byte_count_ff <= byte_count_in;
         index_ff      <= index_in;
      end
   end

   // field payload
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 16'd0;
         acc_ff    <= 16'd0;
      end else begin
         offset_ff <= offset_in;
         acc_ff    <= acc_in;
      end
   end

endmodule

// ----- hw/rtl/hrhp_queue.sv -----
// hrhp_queue: short first-in first-out queue of halfword entries between
// the front and the back. Depends on hrhp_pkg.
module hrhp_queue #(
   parameter int Depth = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hrhp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output hrhp_pkg::entry_type head_entry
);
   import hrhp_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   entry_type slots_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign full       = (count_ff == FullCount);
   assign not_empty  = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/hrhp_back.sv -----
// hrhp_back: takes entries from the queue, forms the flash address and
// holds the result in the output register. Depends on hrhp_pkg.
module hrhp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         flash_base,
   input  logic                entry_valid,
   input  hrhp_pkg::entry_type entry,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [31:0]         out_address,
   output logic [15:0]         out_halfword,
   output logic [6:0]          out_word_index,
   output logic                out_last
);
   import hrhp_pkg::*;

   logic        valid_ff, valid_in;
   logic [31:0] address_ff, address_in;
   entry_type   entry_ff;

   // output register loads when empty or being drained
   assign pop        = entry_valid && (!valid_ff || out_ready);
   assign address_in = (flash_base | {16'd0, entry.offset})
                       + {24'd0, entry.word_index, 1'b0};

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         address_ff <= address_in;
         entry_ff   <= entry;
      end
   end

   assign out_valid      = valid_ff;
   assign out_address    = address_ff;
   assign out_halfword   = entry_ff.halfword;
   assign out_word_index = entry_ff.word_index;
   assign out_last       = entry_ff.last;

endmodule

// ----- hw/rtl/hex_record_halfword_parser_unit.sv -----
// hex_record_halfword_parser_unit: top level of the hex record parser.
// Depends on hrhp_pkg, hrhp_front, hrhp_queue and hrhp_back.
//
// Takes one ASCII character of a hex record per transfer and returns each
// data halfword with its flash address, its index in the record and a last
// mark. A character is taken every cycle while the halfword queue has room;
// a halfword passes through the queue and then the output register after its
// fourth digit, and the queue of QUEUE_DEPTH entries lets the character
// side keep going while the result side stalls. The user must write
// flash_base through the csr channel only while idle; the block does not enforce it.
module hex_record_halfword_parser_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: flash_base
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [31:0] csr_tdata,    // [31:0] flash_base
   // characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] character
   // halfwords
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // [31:0] address, [47:32] halfword,
                                     // [54:48] word_index, [55] zero
   output logic        rsp_tlast     // last halfword of the record
);
   import hrhp_pkg::*;

   logic [31:0] flash_base_ff;
   logic        q_full;
   logic        q_not_empty;
   logic        push;
   logic        pop;
   entry_type   push_entry;
   entry_type   head_entry;
   logic [31:0] out_address;
   logic [15:0] out_halfword;
   logic [6:0]  out_word_index;

   assign csr_tready = 1'b1;
   assign req_tready = !q_full;

   // flash base register
   always_ff @(posedge clock) begin
      if (reset) begin
         flash_base_ff <= 32'd0;
      end else if (csr_tvalid) begin
         flash_base_ff <= csr_tdata;
      end
   end

   hrhp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .char_valid (req_tvalid && req_tready),
      .char_data  (req_tdata),
      .push       (push),
      .push_entry (push_entry)
   );

   hrhp_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .not_empty  (q_not_empty),
      .head_entry (head_entry)
   );

   hrhp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .flash_base     (flash_base_ff),
      .entry_valid    (q_not_empty),
      .entry          (head_entry),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_address    (out_address),
      .out_halfword   (out_halfword),
      .out_word_index (out_word_index),
      .out_last       (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_word_index, out_halfword, out_address};

endmodule
